@@ src/bst_pkg.sv @@
// Shared types, constants and helpers for the brace/string/identifier tokenizer.
`timescale 1ns / 1ps
package bst_pkg;

	localparam int POS_BITS  = 16;
	localparam int OUT_POS_W = 16;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int RES_SLOTS = 3;

	typedef enum logic [1:0] {
		MODE_BETWEEN = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_STRING  = 2'd2,
		MODE_IDENT   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		K_LBRACE  = 3'd0,
		K_RBRACE  = 3'd1,
		K_STRING  = 3'd2,
		K_IDENT   = 3'd3,
		K_UNKNOWN = 3'd4,
		K_EOF     = 3'd5
	} kind_t;

	typedef struct packed {
		logic                event_res;
		logic [2:0]          kind;
		logic [7:0]          char_out;
		logic [POS_BITS-1:0] line;
		logic [POS_BITS-1:0] column;
	} res_t;

	typedef struct packed {
		res_t [RES_SLOTS-1:0] r;
		logic [1:0]           cnt;
	} bundle_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return is_letter(c) || (c == CH_UNDER);
	endfunction

	function automatic logic is_ident_rest(input logic [7:0] c);
		return is_ident_start(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [POS_BITS-1:0] v);
		logic [POS_BITS+OUT_POS_W-1:0] t;
		t = {{OUT_POS_W{1'b0}}, v};
		return t[OUT_POS_W-1:0];
	endfunction

	function automatic res_t mk_res(input logic ev, input kind_t k, input logic [7:0] ch,
			input logic [POS_BITS-1:0] ln, input logic [POS_BITS-1:0] col);
		res_t r;
		r.event_res = ev;
		r.kind      = k;
		r.char_out  = ch;
		r.line      = ln;
		r.column    = col;
		return r;
	endfunction

endpackage

@@ src/bst_scan.sv @@
// Scanner state and per-word classification producing up to three results.
`timescale 1ns / 1ps
module bst_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       char_in,
	input  logic             end_of_input,
	output bst_pkg::bundle_t bundle
);
	import bst_pkg::*;

	mode_t               mode_q, mode_n;
	logic [POS_BITS-1:0] line_q, line_n;
	logic [POS_BITS-1:0] col_q, col_n;
	logic [POS_BITS-1:0] start_q, start_n;
	logic                fin_q, fin_n;

	always_comb begin
		logic [1:0] n;
		logic       do_between;
		logic       do_step;
		bundle_t    b;
		b          = '0;
		n          = 2'd0;
		do_between = 1'b0;
		do_step    = 1'b0;
		mode_n     = mode_q;
		start_n    = start_q;
		fin_n      = fin_q;
		if (fin_q) begin
			// idle after end of file
		end else if (end_of_input) begin
			if (mode_q == MODE_IDENT) begin
				b.r[n] = mk_res(1'b1, K_IDENT, 8'h00, line_q, start_q);
				n = n + 2'd1;
			end else if (mode_q == MODE_STRING) begin
				b.r[n] = mk_res(1'b1, K_UNKNOWN, 8'h00, line_q, start_q);
				n = n + 2'd1;
			end
			b.r[n] = mk_res(1'b1, K_EOF, 8'h00, line_q, col_q);
			n = n + 2'd1;
			mode_n = MODE_BETWEEN;
			fin_n  = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_ident_rest(char_in)) begin
						b.r[n] = mk_res(1'b0, K_LBRACE, char_in, line_q, start_q);
						n = n + 2'd1;
						do_step = 1'b1;
					end else begin
						b.r[n] = mk_res(1'b1, K_IDENT, 8'h00, line_q, start_q);
						n = n + 2'd1;
						mode_n = MODE_BETWEEN;
						do_between = 1'b1;
					end
				end
				MODE_STRING: begin
					if (char_in == CH_QUOTE) begin
						b.r[n] = mk_res(1'b1, K_STRING, 8'h00, line_q, start_q);
						n = n + 2'd1;
						mode_n = MODE_BETWEEN;
						do_step = 1'b1;
					end else if (char_in == CH_LF) begin
						b.r[n] = mk_res(1'b1, K_UNKNOWN, 8'h00, line_q, start_q);
						n = n + 2'd1;
						mode_n = MODE_BETWEEN;
						do_between = 1'b1;
					end else begin
						b.r[n] = mk_res(1'b0, K_LBRACE, char_in, line_q, start_q);
						n = n + 2'd1;
						do_step = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (char_in == CH_LF) begin
						mode_n = MODE_BETWEEN;
						do_between = 1'b1;
					end else begin
						do_step = 1'b1;
					end
				end
				MODE_BETWEEN: begin
					do_between = 1'b1;
				end
			endcase
			if (do_between) begin
				do_step = 1'b1;
				if (is_space(char_in)) begin
					// skip
				end else if (char_in == CH_HASH) begin
					mode_n = MODE_COMMENT;
				end else begin
					start_n = col_q;
					if (char_in == CH_LBRACE || char_in == CH_RBRACE) begin
						b.r[n] = mk_res(1'b0, K_LBRACE, char_in, line_q, start_n);
						n = n + 2'd1;
						b.r[n] = mk_res(1'b1, (char_in == CH_LBRACE) ? K_LBRACE : K_RBRACE,
							8'h00, line_q, start_n);
						n = n + 2'd1;
					end else if (char_in == CH_QUOTE) begin
						mode_n = MODE_STRING;
					end else if (is_ident_start(char_in)) begin
						b.r[n] = mk_res(1'b0, K_LBRACE, char_in, line_q, start_n);
						n = n + 2'd1;
						mode_n = MODE_IDENT;
					end else begin
						b.r[n] = mk_res(1'b0, K_LBRACE, char_in, line_q, start_n);
						n = n + 2'd1;
						b.r[n] = mk_res(1'b1, K_UNKNOWN, 8'h00, line_q, start_n);
						n = n + 2'd1;
					end
				end
			end
		end
		line_n = line_q;
		col_n  = col_q;
		if (do_step) begin
			if (char_in == CH_LF) begin
				line_n = sat_inc(line_q);
				col_n  = POS_ONE;
			end else begin
				col_n = sat_inc(col_q);
			end
		end
		b.cnt  = n;
		bundle = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			line_q  <= POS_ONE;
			col_q   <= POS_ONE;
			start_q <= POS_ONE;
			fin_q   <= 1'b0;
		end else if (acc) begin
			mode_q  <= mode_n;
			line_q  <= line_n;
			col_q   <= col_n;
			start_q <= start_n;
			fin_q   <= fin_n;
		end
	end

endmodule

@@ src/bst_outq.sv @@
// Result register: holds one word's results and hands them out one per cycle while out_stall is low.
`timescale 1ns / 1ps
module bst_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  bst_pkg::bundle_t bundle,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_stall,
	output bst_pkg::res_t    res,
	output logic             res_last
);
	import bst_pkg::*;

	res_t [RES_SLOTS-1:0] buf_q;
	logic [1:0]           cnt_q;
	logic [1:0]           idx_q;
	logic                 take;
	logic                 done;

	assign out_valid = (cnt_q != 2'd0);
	assign res       = buf_q[idx_q];
	assign res_last  = (idx_q == cnt_q - 2'd1);
	assign take      = out_valid && !out_stall;
	assign done      = take && res_last;
	assign can_load  = !out_valid || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (acc && bundle.cnt != 2'd0) begin
			cnt_q <= bundle.cnt;
			idx_q <= 2'd0;
		end else if (done) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && bundle.cnt != 2'd0) begin
			buf_q <= bundle.r;
		end
	end

endmodule

@@ src/brace_string_ident_tokenizer.sv @@
// Top level of the brace/string/identifier tokenizer.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall   | char_in, end_of_input
//   result  | out       | out_valid/out_stall | event_res, kind, char_out,
//           |           |                     | token_line, token_column, last
//
// One input word is taken per cycle while in_stall is low; its 0 to 3 results are computed in the
// same cycle and land in the result register, which drains one per cycle while out_stall is low.
// A word with two or three results holds in_stall high until its last result is taken.
// Reset starts between tokens at line 1, column 1; no clearing pass.
// After end of file is reported, further words are taken and dropped.
`timescale 1ns / 1ps
module brace_string_ident_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_in,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        event_res,
	output logic [2:0]  kind,
	output logic [7:0]  char_out,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        last
);
	import bst_pkg::*;

	bundle_t bundle;
	res_t    res;
	logic    can_load;
	logic    acc;

	assign in_stall = !can_load;
	assign acc      = in_valid && can_load;

	bst_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.char_in      (char_in),
		.end_of_input (end_of_input),
		.bundle       (bundle)
	);

	bst_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.bundle    (bundle),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.res_last  (last)
	);

	assign event_res    = res.event_res;
	assign kind         = res.kind;
	assign char_out     = res.char_out;
	assign token_line   = to_out_pos(res.line);
	assign token_column = to_out_pos(res.column);

endmodule

@@ src/bst_chk.sv @@
// Port-level checks for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
module bst_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        event_res,
	input logic [2:0]  kind,
	input logic [7:0]  char_out,
	input logic [15:0] token_line,
	input logic [15:0] token_column,
	input logic        last
);
	import bst_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(kind)
			&& $stable(char_out) && $stable(token_line) && $stable(token_column)
			&& $stable(last))
		else $error("stalled result word changed");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res && kind == K_EOF |-> last)
		else $error("eof is not the last result of its word");

	a_eof_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_res && kind == K_EOF |=> !out_valid)
		else $error("result after eof");

	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_res |-> kind == K_LBRACE)
		else $error("character result carries a kind");

	a_end_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res |-> char_out == 8'h00 && token_line != 16'h0000)
		else $error("end result carries a character or a zero line");

endmodule

bind brace_string_ident_tokenizer bst_chk u_bst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.event_res    (event_res),
	.kind         (kind),
	.char_out     (char_out),
	.token_line   (token_line),
	.token_column (token_column),
	.last         (last)
);

@@ test/testbench.sv @@
// Testbench for the brace/string/identifier tokenizer: byte stream in, token words checked out.
`timescale 1ns / 1ps
module testbench;
	import bst_pkg::*;

	typedef struct packed {
		logic        event_res;
		logic [2:0]  kind;
		logic [7:0]  text;
		logic [15:0] line;
		logic [15:0] column;
		logic        last;
	} token_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_in = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        event_res;
	logic [2:0]  kind;
	logic [7:0]  char_out;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        last;

	token_word_t expected_words[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	bit          calm = 1'b0;

	// scanner state as seen from outside
	mode_t       scan_state = MODE_BETWEEN;
	logic [15:0] line_now = 16'd1;
	logic [15:0] column_now = 16'd1;
	logic [15:0] token_start = 16'd1;
	bit          stream_done = 1'b0;

	brace_string_ident_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_res(event_res),
		.kind(kind),
		.char_out(char_out),
		.token_line(token_line),
		.token_column(token_column),
		.last(last)
	);

	always #10 clk = ~clk;

	initial begin
		#40ms;
		$display("Verification failed");
		$finish;
	end

	function automatic bit ident_head(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
	endfunction

	function automatic bit ident_body(logic [7:0] c);
		return ident_head(c) || (c >= "0" && c <= "9");
	endfunction

	function void push_word(logic ev, kind_t k, logic [7:0] ch, logic [15:0] col);
		token_word_t w;
		w.event_res = ev;
		w.kind      = k;
		w.text      = ch;
		w.line      = line_now;
		w.column    = col;
		w.last      = 1'b0;
		expected_words.insert(expected_words.size(), w);
	endfunction

	function void advance(logic [7:0] c);
		if (c == CH_LF) begin
			if (line_now != POS_MAX)
				line_now = line_now + 16'd1;
			column_now = 16'd1;
		end else if (column_now != POS_MAX) begin
			column_now = column_now + 16'd1;
		end
	endfunction

	function void scan_between(logic [7:0] c);
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
			advance(c);
		end else if (c == CH_HASH) begin
			scan_state = MODE_COMMENT;
			advance(c);
		end else begin
			token_start = column_now;
			if (c == CH_LBRACE || c == CH_RBRACE) begin
				push_word(1'b0, K_LBRACE, c, token_start);
				push_word(1'b1, (c == CH_LBRACE) ? K_LBRACE : K_RBRACE, 8'h00, token_start);
			end else if (c == CH_QUOTE) begin
				scan_state = MODE_STRING;
			end else if (ident_head(c)) begin
				push_word(1'b0, K_LBRACE, c, token_start);
				scan_state = MODE_IDENT;
			end else begin
				push_word(1'b0, K_LBRACE, c, token_start);
				push_word(1'b1, K_UNKNOWN, 8'h00, token_start);
			end
			advance(c);
		end
	endfunction

	function void predict_tokens(logic [7:0] c, logic eoi);
		int          first;
		token_word_t w;
		first = expected_words.size();
		if (stream_done)
			return;
		if (eoi) begin
			if (scan_state == MODE_IDENT)
				push_word(1'b1, K_IDENT, 8'h00, token_start);
			else if (scan_state == MODE_STRING)
				push_word(1'b1, K_UNKNOWN, 8'h00, token_start);
			scan_state = MODE_BETWEEN;
			push_word(1'b1, K_EOF, 8'h00, column_now);
			stream_done = 1'b1;
		end else begin
			case (scan_state)
				MODE_IDENT: begin
					if (ident_body(c)) begin
						push_word(1'b0, K_LBRACE, c, token_start);
						advance(c);
					end else begin
						push_word(1'b1, K_IDENT, 8'h00, token_start);
						scan_state = MODE_BETWEEN;
						scan_between(c);
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						advance(c);
						push_word(1'b1, K_STRING, 8'h00, token_start);
						scan_state = MODE_BETWEEN;
					end else if (c == CH_LF) begin
						push_word(1'b1, K_UNKNOWN, 8'h00, token_start);
						scan_state = MODE_BETWEEN;
						scan_between(c);
					end else begin
						push_word(1'b0, K_LBRACE, c, token_start);
						advance(c);
					end
				end
				MODE_COMMENT: begin
					if (c == CH_LF) begin
						scan_state = MODE_BETWEEN;
						scan_between(c);
					end else begin
						advance(c);
					end
				end
				default: scan_between(c);
			endcase
		end
		if (expected_words.size() > first) begin
			w = expected_words[expected_words.size() - 1];
			w.last = 1'b1;
			expected_words[expected_words.size() - 1] = w;
		end
	endfunction

	task automatic send_word(input logic [7:0] c, input logic eoi);
		while (!calm && $urandom_range(0, 99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		char_in      <= c;
		end_of_input <= eoi;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		predict_tokens(c, eoi);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	function automatic logic [7:0] random_head_char();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return 8'(int'("a") + r);
		if (r < 52)
			return 8'(int'("A") + r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] random_body_char();
		if ($urandom_range(0, 5) == 0)
			return 8'(int'("0") + $urandom_range(0, 9));
		return random_head_char();
	endfunction

	function automatic logic [7:0] random_free_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_QUOTE || c == CH_LF);
		return c;
	endfunction

	task automatic send_random_token();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		n = $urandom_range(0, 6);
		if (pick < 30) begin
			send_word(random_head_char(), 1'b0);
			repeat (n) send_word(random_body_char(), 1'b0);
		end else if (pick < 45) begin
			send_word(CH_QUOTE, 1'b0);
			repeat (n) send_word(random_free_byte(), 1'b0);
			send_word(($urandom_range(0, 99) < 85) ? CH_QUOTE : CH_LF, 1'b0);
		end else if (pick < 55) begin
			send_word($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE, 1'b0);
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: send_word(CH_SPACE, 1'b0);
				1: send_word(CH_TAB, 1'b0);
				2: send_word(CH_CR, 1'b0);
				default: send_word(CH_LF, 1'b0);
			endcase
		end else if (pick < 78) begin
			send_word(CH_HASH, 1'b0);
			repeat (n) send_word(random_free_byte(), 1'b0);
			send_word(CH_LF, 1'b0);
		end else begin
			send_word(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic test_single_tokens();
		send_word(CH_LBRACE, 1'b0);
		send_word(CH_RBRACE, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(CH_SPACE, 1'b0);
		send_word(CH_TAB, 1'b0);
		send_word(CH_CR, 1'b0);
		send_word(CH_LF, 1'b0);
	endtask

	task automatic test_strings();
		send_text("\"\"");
		send_text("\"~\"");
		// newline cuts the string short
		send_text("\"q\n");
	endtask

	task automatic test_identifiers_and_comments();
		send_text("_Z9{");
		send_word("a", 1'b0);
		send_word(8'h80, 1'b0);
		send_text("#x\"}\n");
	endtask

	task automatic test_random_stream();
		int goal;
		goal = bytes_sent + 120;
		calm = 1'b1;
		while (bytes_sent < goal) begin
			if (bytes_sent >= goal - 70)
				calm = 1'b0;
			send_random_token();
		end
		calm = 1'b0;
		send_word(CH_LF, 1'b0);
	endtask

	task automatic test_end_of_input();
		case ($urandom_range(0, 2))
			0: send_text("tail");
			1: send_text("\"open");
			default: send_text("x ");
		endcase
		send_word(8'($urandom_range(0, 255)), 1'b1);
		// everything after end of file is dropped
		repeat (6) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 18);

	always @(negedge clk) begin
		token_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: event_res %0d kind %0d char_out %h",
					event_res, kind, char_out);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, event_res);
					mismatches++;
				end
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatches++;
				end
				if (char_out !== want.text) begin
					$error("char_out: expected %h, got %h", want.text, char_out);
					mismatches++;
				end
				if (token_line !== want.line) begin
					$error("token_line: expected %0d, got %0d", want.line, token_line);
					mismatches++;
				end
				if (token_column !== want.column) begin
					$error("token_column: expected %0d, got %0d", want.column, token_column);
					mismatches++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_tokens();
		test_strings();
		test_identifiers_and_comments();
		test_random_stream();
		test_end_of_input();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
